// ----- design/mchw_pkg.sv -----
// shared types, constants and register codes for the heartbeat watchdog
package mchw_pkg;

  // channel count and the mask of monitored check-in bits
  localparam int unsigned CHANNELS  = 4;
  localparam int unsigned CHECKIN_W = 4;
  localparam logic [CHECKIN_W-1:0] MON_MASK =
    CHECKIN_W'((64'd1 << CHANNELS) - 64'd1);

  // counter and register widths
  localparam int unsigned TICK_W  = 16;
  localparam int unsigned PULSE_W = 8;
  localparam int unsigned HALF_W  = PULSE_W + 1;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // phase codes
  localparam logic [1:0] PH_STARTUP = 2'd0;
  localparam logic [1:0] PH_WINDOW  = 2'd1;
  localparam logic [1:0] PH_BLINK   = 2'd2;
  localparam logic [1:0] PH_PAUSE   = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STARTUP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HALF    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PULSES  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PAUSE   = 3'd4;

  // register reset values
  localparam logic [TICK_W-1:0]  RST_STARTUP = 16'd2000;
  localparam logic [TICK_W-1:0]  RST_WINDOW  = 16'd2000;
  localparam logic [TICK_W-1:0]  RST_HALF    = 16'd100;
  localparam logic [PULSE_W-1:0] RST_PULSES  = 8'd10;
  localparam logic [TICK_W-1:0]  RST_PAUSE   = 16'd500;

  typedef struct packed {
    logic [TICK_W-1:0]  startup_ticks;
    logic [TICK_W-1:0]  window_ticks;
    logic [TICK_W-1:0]  blink_half_ticks;
    logic [PULSE_W-1:0] blink_pulses;
    logic [TICK_W-1:0]  pause_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0]           phase;
    logic [TICK_W-1:0]    tick_count;
    logic [CHECKIN_W-1:0] seen_mask;
    logic [CHECKIN_W-1:0] latched_fault;
    logic [HALF_W-1:0]    half_count;
  } wd_state_t;

  typedef struct packed {
    logic [CHECKIN_W-1:0] fault_mask;
    logic                 indicator_on;
    logic                 blinking;
    logic                 window_open;
  } result_t;

endpackage

// ----- design/mchw_if.sv -----
// request channel interfaces for tick input and status output
interface mchw_in_if import mchw_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CHECKIN_W-1:0] checkin;

  modport source (output valid, output checkin, input ready);
  modport sink   (input valid, input checkin, output ready);
endinterface

interface mchw_out_if import mchw_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CHECKIN_W-1:0] fault_mask;
  logic                 indicator_on;
  logic                 blinking;
  logic                 window_open;

  modport source (output valid, output fault_mask, output indicator_on,
                  output blinking, output window_open, input ready);
  modport sink   (input valid, input fault_mask, input indicator_on,
                  input blinking, input window_open, output ready);
endinterface

// ----- design/mchw_step.sv -----
// next-state and status logic for one tick of the watchdog
module mchw_step import mchw_pkg::*; (
  input  cfg_t                 cfg,
  input  wd_state_t            cur,
  input  logic [CHECKIN_W-1:0] checkin,
  output wd_state_t            nxt,
  output result_t              res
);

  logic [CHECKIN_W-1:0] chk;
  logic [CHECKIN_W-1:0] seen_new;
  logic [TICK_W-1:0]    tick_inc;
  logic [HALF_W-1:0]    half_inc;
  logic [TICK_W-1:0]    win_eff;
  logic [TICK_W-1:0]    half_eff;
  logic [PULSE_W-1:0]   pulses_eff;
  logic [HALF_W-1:0]    half_limit;
  wd_state_t            st;

  // zero window, blink half and pulse settings count as one
  assign win_eff    = (cfg.window_ticks == '0) ? TICK_W'(1) : cfg.window_ticks;
  assign half_eff   = (cfg.blink_half_ticks == '0) ? TICK_W'(1) : cfg.blink_half_ticks;
  assign pulses_eff = (cfg.blink_pulses == '0) ? PULSE_W'(1) : cfg.blink_pulses;
  assign half_limit = {pulses_eff, 1'b0};

  assign chk = checkin & MON_MASK;

  // startup or pause that ran out opens the window first
  always_comb begin
    st = cur;
    if ((cur.phase == PH_STARTUP && cur.tick_count >= cfg.startup_ticks) ||
        (cur.phase == PH_PAUSE && cur.tick_count >= cfg.pause_ticks)) begin
      st.phase      = PH_WINDOW;
      st.tick_count = '0;
      st.seen_mask  = '0;
    end
  end

  assign tick_inc = st.tick_count + TICK_W'(1);
  assign half_inc = st.half_count + HALF_W'(1);
  assign seen_new = (st.seen_mask | chk) & MON_MASK;

  // phase update
  always_comb begin
    nxt              = st;
    res.indicator_on = 1'b0;
    res.blinking     = 1'b0;
    res.window_open  = 1'b0;
    case (st.phase)
      PH_STARTUP, PH_PAUSE: begin
        nxt.tick_count = tick_inc;
      end
      PH_WINDOW: begin
        res.window_open = 1'b1;
        nxt.seen_mask   = seen_new;
        nxt.tick_count  = tick_inc;
        if (seen_new == MON_MASK) begin
          nxt.phase      = PH_PAUSE;
          nxt.tick_count = '0;
        end else if (tick_inc >= win_eff) begin
          nxt.latched_fault = MON_MASK & ~seen_new;
          nxt.phase         = PH_BLINK;
          nxt.tick_count    = '0;
          nxt.half_count    = '0;
        end
      end
      PH_BLINK: begin
        res.blinking     = 1'b1;
        res.indicator_on = ~st.half_count[0];
        nxt.tick_count   = tick_inc;
        if (tick_inc >= half_eff) begin
          nxt.tick_count = '0;
          nxt.half_count = half_inc;
          if (half_inc >= half_limit) begin
            nxt.phase      = PH_PAUSE;
            nxt.half_count = '0;
          end
        end
      end
      default: begin
        nxt = st;
      end
    endcase
    res.fault_mask = nxt.latched_fault;
  end

endmodule

// ----- design/multi_channel_heartbeat_watchdog_core.sv -----
// Multi-channel heartbeat watchdog core.
// Each request on in_ch is one tick carrying the checkin mask of the channels
// seen in that tick. Each tick yields exactly one status request on out_ch:
// fault_mask, indicator_on, blinking and window_open for the tick just handled.
// The block runs startup delay, check-in window, fault blink and pause phases,
// all counted in ticks, never in clock cycles.
// A tick accepted on in_ch is held in the tick register, then handled, and its
// status is written to the status register, from which it is offered on out_ch.
// Throughput: one tick per cycle while out_ch does not stall; the tick register and the status register
// form a two-stage pipeline, and the whole phase update is one pass of
// compares and counter increments between them.
// When out_ch stalls, the status register holds, the tick register fills, and
// in_ch.ready drops until the status request is taken.
// Reset (rst_n low, synchronous) empties both stages, loads the register
// defaults and puts the block in the startup delay with a zero fault mask.
// cfg_we writes register cfg_index with cfg_wdata; unused indexes are ignored.
module multi_channel_heartbeat_watchdog_core import mchw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  mchw_in_if.sink               in_ch,
  mchw_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t                 cfg_r;
  wd_state_t            state_r;
  wd_state_t            state_nxt;
  result_t              res_nxt;
  result_t              res_r;
  logic                 s1_valid_r;
  logic [CHECKIN_W-1:0] s1_checkin_r;
  logic                 out_valid_r;
  logic                 advance;

  // pipeline handshake
  assign advance      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || advance;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.startup_ticks    <= RST_STARTUP;
      cfg_r.window_ticks     <= RST_WINDOW;
      cfg_r.blink_half_ticks <= RST_HALF;
      cfg_r.blink_pulses     <= RST_PULSES;
      cfg_r.pause_ticks      <= RST_PAUSE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STARTUP: cfg_r.startup_ticks    <= cfg_wdata;
        REG_WINDOW:  cfg_r.window_ticks     <= cfg_wdata;
        REG_HALF:    cfg_r.blink_half_ticks <= cfg_wdata;
        REG_PULSES:  cfg_r.blink_pulses     <= cfg_wdata[PULSE_W-1:0];
        REG_PAUSE:   cfg_r.pause_ticks      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // tick register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_checkin_r <= in_ch.checkin;
    end
  end

  // phase logic
  mchw_step u_step (
    .cfg     (cfg_r),
    .cur     (state_r),
    .checkin (s1_checkin_r),
    .nxt     (state_nxt),
    .res     (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{phase: PH_STARTUP, tick_count: '0, seen_mask: '0,
                   latched_fault: '0, half_count: '0};
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // status register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.fault_mask   = res_r.fault_mask;
  assign out_ch.indicator_on = res_r.indicator_on;
  assign out_ch.blinking     = res_r.blinking;
  assign out_ch.window_open  = res_r.window_open;

  // blinking only follows a window that missed a channel
  a_blink_has_fault: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.phase == PH_BLINK |-> state_r.latched_fault != '0)
    else $error("blink phase with empty fault mask");

  // a complete window never stays open
  a_window_incomplete: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.phase == PH_WINDOW |-> state_r.seen_mask != MON_MASK)
    else $error("window open with every channel seen");

  // status flags are mutually consistent
  a_status_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(res_r.blinking && res_r.window_open) &&
                    (!res_r.indicator_on || res_r.blinking))
    else $error("inconsistent status flags");

  // state only moves when a tick is handled
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(state_r))
    else $error("watchdog state changed without a tick");

endmodule

// ----- sim/multi_channel_heartbeat_watchdog_core_test.sv -----
// self-checking testbench for the heartbeat watchdog core: directed table, then random phases
module multi_channel_heartbeat_watchdog_core_test;
  import mchw_pkg::*;

  // directed table row kinds and unused register slots
  typedef enum logic {ROW_TICK, ROW_CFG} row_kind_e;
  typedef enum {FEED_FULL, FEED_SHORT, FEED_NOISE} feed_e;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;
  localparam result_t NO_WANT = '0;
  localparam int unsigned RANDOM_TICKS = 650;

  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic [CHECKIN_W-1:0]  chk;
    logic                  typed;
    result_t               want;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  mchw_in_if  in_ch ();
  mchw_out_if out_ch ();

  multi_channel_heartbeat_watchdog_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // directed stimulus: zero registers treated as one, check-in on the opening tick,
  // ignored register slots, a pause cut short by a smaller setting, register extremes
  stim_row_t plan [0:30] = '{
    '{ROW_TICK, REG_STARTUP,   16'h0000, 4'hF, 1'b1, '{4'h0, 1'b0, 1'b0, 1'b0}},
    '{ROW_CFG,  REG_STARTUP,   16'h0000, 4'h0, 1'b0, NO_WANT},
    '{ROW_CFG,  REG_WINDOW,    16'h0000, 4'h0, 1'b0, NO_WANT},
    '{ROW_CFG,  REG_HALF,      16'h0000, 4'h0, 1'b0, NO_WANT},
    '{ROW_CFG,  REG_PULSES,    16'h0000, 4'h0, 1'b0, NO_WANT},
    '{ROW_CFG,  REG_PAUSE,     16'h0000, 4'h0, 1'b0, NO_WANT},
    '{ROW_TICK, REG_STARTUP,   16'h0000, 4'h0, 1'b1, '{4'hF, 1'b0, 1'b0, 1'b1}},
    '{ROW_TICK, REG_STARTUP,   16'h0000, 4'h0, 1'b1, '{4'hF, 1'b1, 1'b1, 1'b0}},
    '{ROW_TICK, REG_STARTUP,   16'h0000, 4'h0, 1'b1, '{4'hF, 1'b0, 1'b1, 1'b0}},
    '{ROW_TICK, REG_STARTUP,   16'h0000, 4'hF, 1'b1, '{4'hF, 1'b0, 1'b0, 1'b1}},
    '{ROW_CFG,  REG_WINDOW,    16'h0003, 4'h0, 1'b0, NO_WANT},
    '{ROW_TICK, REG_STARTUP,   16'h0000, 4'h5, 1'b1, '{4'hF, 1'b0, 1'b0, 1'b1}},
    '{ROW_TICK, REG_STARTUP,   16'h0000, 4'h2, 1'b0, NO_WANT},
    '{ROW_TICK, REG_STARTUP,   16'h0000, 4'h0, 1'b0, NO_WANT},
    '{ROW_TICK, REG_STARTUP,   16'h0000, 4'hF, 1'b0, NO_WANT},
    '{ROW_CFG,  REG_UNUSED_LO, 16'hFFFF, 4'h0, 1'b0, NO_WANT},
    '{ROW_CFG,  REG_UNUSED_HI, 16'hFFFF, 4'h0, 1'b0, NO_WANT},
    '{ROW_CFG,  REG_PAUSE,     16'hFFFF, 4'h0, 1'b0, NO_WANT},
    '{ROW_TICK, REG_STARTUP,   16'h0000, 4'hA, 1'b0, NO_WANT},
    '{ROW_TICK, REG_STARTUP,   16'h0000, 4'h0, 1'b0, NO_WANT},
    '{ROW_TICK, REG_STARTUP,   16'h0000, 4'hF, 1'b0, NO_WANT},
    '{ROW_CFG,  REG_PAUSE,     16'h0001, 4'h0, 1'b0, NO_WANT},
    '{ROW_TICK, REG_STARTUP,   16'h0000, 4'hF, 1'b0, NO_WANT},
    '{ROW_CFG,  REG_STARTUP,   16'hFFFF, 4'h0, 1'b0, NO_WANT},
    '{ROW_CFG,  REG_WINDOW,    16'hFFFF, 4'h0, 1'b0, NO_WANT},
    '{ROW_TICK, REG_STARTUP,   16'h0000, 4'h1, 1'b0, NO_WANT},
    '{ROW_TICK, REG_STARTUP,   16'h0000, 4'h0, 1'b0, NO_WANT},
    '{ROW_TICK, REG_STARTUP,   16'h0000, 4'hE, 1'b0, NO_WANT},
    '{ROW_TICK, REG_STARTUP,   16'h0000, 4'h0, 1'b0, NO_WANT},
    '{ROW_CFG,  REG_HALF,      16'hFFFF, 4'h0, 1'b0, NO_WANT},
    '{ROW_CFG,  REG_PULSES,    16'hFFFF, 4'h0, 1'b0, NO_WANT}
  };

  // watchdog state and register copy kept by the testbench
  logic [1:0]           wd_phase;
  logic [TICK_W-1:0]    wd_ticks;
  logic [CHECKIN_W-1:0] wd_seen;
  logic [CHECKIN_W-1:0] wd_fault;
  logic [HALF_W-1:0]    wd_halves;
  cfg_t                 wd_cfg;

  result_t pending_status [$];
  int      mismatch_count;
  int      burst_left;
  bit      steady;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #3000000;
    $display("multi_channel_heartbeat_watchdog_core_test: FAIL");
    $finish;
  end

  // advance the watchdog by one tick and return the status it reports
  function automatic result_t next_status(input logic [CHECKIN_W-1:0] raw);
    logic [CHECKIN_W-1:0] chk;
    result_t              r;
    int unsigned          win_len;
    int unsigned          half_len;
    int unsigned          pulse_len;
    chk       = raw & MON_MASK;
    r         = '0;
    win_len   = (wd_cfg.window_ticks == '0) ? 1 : wd_cfg.window_ticks;
    half_len  = (wd_cfg.blink_half_ticks == '0) ? 1 : wd_cfg.blink_half_ticks;
    pulse_len = (wd_cfg.blink_pulses == '0) ? 1 : wd_cfg.blink_pulses;

    // an expired startup or pause hands over to a fresh window this tick
    if ((wd_phase == PH_STARTUP && wd_ticks >= wd_cfg.startup_ticks) ||
        (wd_phase == PH_PAUSE && wd_ticks >= wd_cfg.pause_ticks)) begin
      wd_phase = PH_WINDOW;
      wd_ticks = '0;
      wd_seen  = '0;
    end

    case (wd_phase)
      PH_STARTUP, PH_PAUSE: begin
        wd_ticks = wd_ticks + 1'b1;
      end
      PH_WINDOW: begin
        r.window_open = 1'b1;
        wd_seen  = (wd_seen | chk) & MON_MASK;
        wd_ticks = wd_ticks + 1'b1;
        if (wd_seen == MON_MASK) begin
          wd_phase = PH_PAUSE;
          wd_ticks = '0;
        end else if (wd_ticks >= win_len) begin
          wd_fault  = MON_MASK & ~wd_seen;
          wd_phase  = PH_BLINK;
          wd_ticks  = '0;
          wd_halves = '0;
        end
      end
      default: begin
        r.blinking     = 1'b1;
        r.indicator_on = ~wd_halves[0];
        wd_ticks = wd_ticks + 1'b1;
        if (wd_ticks >= half_len) begin
          wd_ticks  = '0;
          wd_halves = wd_halves + 1'b1;
          if (wd_halves >= 2 * pulse_len) begin
            wd_phase  = PH_PAUSE;
            wd_halves = '0;
          end
        end
      end
    endcase

    r.fault_mask = wd_fault;
    return r;
  endfunction

  // random register value, mostly short settings with the odd extreme
  function automatic logic [CFG_DATA_W-1:0] pick_setting(input logic [CFG_IDX_W-1:0] idx);
    int unsigned roll;
    roll = $urandom_range(0, 15);
    if (roll == 0) return 16'hFFFF;
    if (roll == 1) return 16'h0000;
    case (idx)
      REG_STARTUP: return 16'($urandom_range(0, 8));
      REG_WINDOW:  return 16'($urandom_range(1, 12));
      REG_HALF:    return 16'($urandom_range(1, 4));
      REG_PULSES:  return 16'($urandom_range(1, 4));
      REG_PAUSE:   return 16'($urandom_range(0, 6));
      default:     return 16'($urandom);
    endcase
  endfunction

  // one tick request; the expected status is queued at acceptance
  task automatic send_tick(input logic [CHECKIN_W-1:0] v, input logic typed,
                           input result_t typed_want);
    result_t predicted;
    in_ch.valid   <= 1'b1;
    in_ch.checkin <= v;
    do @(posedge clk); while (!in_ch.ready);
    predicted = next_status(v);
    pending_status.push_back(typed ? typed_want : predicted);
  endtask

  // burst pacing on the tick side
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        in_ch.valid   <= 1'b0;
        in_ch.checkin <= CHECKIN_W'($urandom);
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // stop sending and wait for every status to come back
  task automatic settle_outputs();
    in_ch.valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // single register write, mirrored into the predictor
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_STARTUP: wd_cfg.startup_ticks    = val;
      REG_WINDOW:  wd_cfg.window_ticks     = val;
      REG_HALF:    wd_cfg.blink_half_ticks = val;
      REG_PULSES:  wd_cfg.blink_pulses     = val[PULSE_W-1:0];
      REG_PAUSE:   wd_cfg.pause_ticks      = val;
      default: ;
    endcase
  endtask

  // status side stalls on a pattern that moves through always ready, mostly ready, a regular gap and random ready
  initial begin
    int unsigned stall_cycle;
    stall_cycle = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      stall_cycle++;
      case (stall_cycle[8:7])
        2'd0:    out_ch.ready <= 1'b1;
        2'd1:    out_ch.ready <= ($urandom_range(0, 3) != 0);
        2'd2:    out_ch.ready <= (stall_cycle[2:0] != 3'd5) && (stall_cycle[2:0] != 3'd6);
        default: out_ch.ready <= ($urandom_range(0, 1) == 0);
      endcase
    end
  end

  // compare each status request with the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_status.size() == 0) begin
        $error("status request with no tick waiting");
        mismatch_count++;
      end else begin
        want = pending_status.pop_front();
        if (out_ch.fault_mask !== want.fault_mask) begin
          $error("fault_mask: expected %h, got %h", want.fault_mask, out_ch.fault_mask);
          mismatch_count++;
        end
        if (out_ch.indicator_on !== want.indicator_on) begin
          $error("indicator_on: expected %b, got %b", want.indicator_on, out_ch.indicator_on);
          mismatch_count++;
        end
        if (out_ch.blinking !== want.blinking) begin
          $error("blinking: expected %b, got %b", want.blinking, out_ch.blinking);
          mismatch_count++;
        end
        if (out_ch.window_open !== want.window_open) begin
          $error("window_open: expected %b, got %b", want.window_open, out_ch.window_open);
          mismatch_count++;
        end
      end
    end
  end

  // stimulus
  initial begin
    feed_e                feed;
    int unsigned          sent;
    int unsigned          phase_len;
    logic [CHECKIN_W-1:0] drop;
    logic [CHECKIN_W-1:0] v;

    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.checkin <= '0;
    cfg_we        <= 1'b0;
    cfg_index     <= '0;
    cfg_wdata     <= '0;
    mismatch_count = 0;
    burst_left     = 0;
    steady         = 1'b0;
    wd_phase  = PH_STARTUP;
    wd_ticks  = '0;
    wd_seen   = '0;
    wd_fault  = '0;
    wd_halves = '0;
    wd_cfg    = '{RST_STARTUP, RST_WINDOW, RST_HALF, RST_PULSES, RST_PAUSE};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        settle_outputs();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_tick(plan[i].chk, plan[i].typed, plan[i].want);
        pace_sender();
      end
    end

    // random phases: new settings while idle, then a run of ticks
    sent = 0;
    while (sent < RANDOM_TICKS) begin
      settle_outputs();
      for (int r = REG_STARTUP; r <= REG_PAUSE; r++)
        write_reg(CFG_IDX_W'(r), pick_setting(CFG_IDX_W'(r)));
      if ($urandom_range(0, 3) == 0)
        write_reg(CFG_IDX_W'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)), 16'($urandom));

      case ($urandom_range(0, 19))
        0, 1, 2:          feed = FEED_NOISE;
        3, 4, 5, 6, 7:    feed = FEED_SHORT;
        default:          feed = FEED_FULL;
      endcase
      steady    = ($urandom_range(0, 3) == 0);
      drop      = CHECKIN_W'(1) << $urandom_range(0, CHECKIN_W - 1);
      phase_len = $urandom_range(20, 90);
      if (phase_len > RANDOM_TICKS - sent) phase_len = RANDOM_TICKS - sent;

      repeat (phase_len) begin
        case (feed)
          FEED_FULL:  v = CHECKIN_W'($urandom);
          FEED_SHORT: v = CHECKIN_W'($urandom) & ~drop;
          default:    v = ($urandom_range(0, 4) == 0) ? CHECKIN_W'($urandom) : '0;
        endcase
        send_tick(v, 1'b0, NO_WANT);
        pace_sender();
        sent++;
      end
    end

    // drain and report
    settle_outputs();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("multi_channel_heartbeat_watchdog_core_test: PASS");
    end else begin
      $display("multi_channel_heartbeat_watchdog_core_test: FAIL");
    end
    $finish;
  end

endmodule
